### sv/lpc_pkg.sv
package lpc_pkg;

    // Number of cache entries.
    localparam int CAPACITY = 16;

    // Entry index, scan counter and recency rank widths.
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AGE_W = IDX_W;

    // Fixed field widths.
    localparam int FUNC_W  = 2;
    localparam int KEY_W   = 32;
    localparam int PRICE_W = 32;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ERASE  = 2'd2;

    // One stored entry: key pattern, Q16.16 price and recency rank (0 is newest).
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [PRICE_W-1:0] value;
        logic [AGE_W-1:0]   age;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

### sv/lpc_if.sv
// Request channel: one lookup, insert or erase word.
interface lpc_req_if;
    logic                               valid;
    logic                               ready;
    logic [lpc_pkg::FUNC_W-1:0]         func;
    logic signed [lpc_pkg::KEY_W-1:0]   key;
    logic [lpc_pkg::PRICE_W-1:0]        price;

    modport source (output valid, output func, output key, output price, input ready);
    modport sink   (input valid, input func, input key, input price, output ready);
endinterface

// Response channel: one result word per request.
interface lpc_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               hit;
    logic [lpc_pkg::PRICE_W-1:0]        read_price;
    logic                               evicted;
    logic signed [lpc_pkg::KEY_W-1:0]   evicted_key;

    modport source (output valid, output hit, output read_price, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input hit, input read_price, input evicted,
                    input evicted_key, output ready);
endinterface

### sv/lpc_ram.sv
module lpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/lru_keyed_price_cache_top.sv
// Channel  Dir  Word contents
// req      in   func, key, price
// rsp      out  hit, read_price, evicted, evicted_key
//
// A request makes one pass over the entries when nothing changes and two when
// recency ranks are rewritten, set by the entry memory's single read port: one
// pass reads every entry to match the key, a second pass reads every entry and
// writes back every valid entry to update ranks.
// Reset clears the valid bits and the occupancy at once; no clearing pass is needed.
// A new request is taken while a finished response still waits in the output register.
module lru_keyed_price_cache_top (
    input  logic     clk,
    input  logic     rst_n,
    lpc_req_if.sink  req,
    lpc_rsp_if.source rsp
);

    import lpc_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_UPD    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    // Rank update modes for the writeback pass.
    localparam logic [1:0] MODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_PROMOTE = 2'd1;
    localparam logic [1:0] MODE_INSERT  = 2'd2;
    localparam logic [1:0] MODE_ERASE   = 2'd3;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAPACITY);

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic                pipe_vld_reg;
    logic [IDX_W-1:0]    pipe_idx_reg;
    logic [CAPACITY-1:0] valid_reg;
    logic [CNT_W-1:0]    occ_reg;
    logic [1:0]          mode_reg, mode_next;
    logic                out_valid_reg;

    // Request payload.
    logic [FUNC_W-1:0]   func_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [PRICE_W-1:0]  price_reg;

    // Scan results.
    logic                found_reg;
    logic [IDX_W-1:0]    fslot_reg;
    logic [AGE_W-1:0]    fage_reg;
    logic [PRICE_W-1:0]  fvalue_reg;
    logic                mx_any_reg;
    logic [IDX_W-1:0]    mx_slot_reg;
    logic [AGE_W-1:0]    mx_age_reg;
    logic [KEY_W-1:0]    mx_key_reg;
    logic                free_any_reg;
    logic [IDX_W-1:0]    free_slot_reg;

    // Decision and staged result.
    logic [IDX_W-1:0]    tslot_reg, tslot_next;
    logic [AGE_W-1:0]    tage_reg, tage_next;
    logic                res_hit_reg, res_hit_next;
    logic [PRICE_W-1:0]  res_price_reg, res_price_next;
    logic                res_ev_reg, res_ev_next;
    logic [KEY_W-1:0]    res_evkey_reg, res_evkey_next;
    logic [CAPACITY-1:0] valid_next;
    logic [CNT_W-1:0]    occ_next;

    // Output register.
    logic                out_hit_reg;
    logic [PRICE_W-1:0]  out_price_reg;
    logic                out_ev_reg;
    logic [KEY_W-1:0]    out_evkey_reg;

    logic                req_acc;
    logic                out_load;
    logic                pass_active;
    logic                pass_end;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic                ram_we;
    logic [ENTRY_W-1:0]  ram_wdata;
    entry_t              rd_entry;
    entry_t              wr_entry;

    assign req.ready = (state_reg == S_IDLE);
    assign req_acc   = req.valid && req.ready;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    assign pass_active = (state_reg == S_SCAN) || (state_reg == S_UPD);
    assign pass_end    = pass_active && (cnt_reg == CNT_LAST);

    assign rd_entry  = entry_t'(ram_rdata);
    assign ram_raddr = (cnt_reg < CNT_LAST) ? cnt_reg[IDX_W-1:0] : '0;

    // Entry memory: keys, prices and ranks.
    lpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pipe_idx_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Writeback pass: rewrite the rank of each valid entry, place a new entry.
    always_comb
    begin
        wr_entry = rd_entry;
        case (mode_reg)
            MODE_PROMOTE:
            begin
                if (pipe_idx_reg == tslot_reg)
                begin
                    wr_entry.age = '0;
                end
                else if (rd_entry.age < tage_reg)
                begin
                    wr_entry.age = rd_entry.age + AGE_W'(1);
                end
            end
            MODE_INSERT:
            begin
                if (pipe_idx_reg == tslot_reg)
                begin
                    wr_entry.key   = key_reg;
                    wr_entry.value = price_reg;
                    wr_entry.age   = '0;
                end
                else
                begin
                    wr_entry.age = rd_entry.age + AGE_W'(1);
                end
            end
            MODE_ERASE:
            begin
                if (rd_entry.age > tage_reg)
                begin
                    wr_entry.age = rd_entry.age - AGE_W'(1);
                end
            end
            default:
            begin
                wr_entry = rd_entry;
            end
        endcase
    end

    assign ram_wdata = ENTRY_W'(wr_entry);
    assign ram_we    = (state_reg == S_UPD) && pipe_vld_reg && valid_reg[pipe_idx_reg];

    // Decision after the scan: result fields, target slot and bookkeeping.
    always_comb
    begin
        mode_next      = MODE_NONE;
        tslot_next     = fslot_reg;
        tage_next      = fage_reg;
        res_hit_next   = 1'b0;
        res_price_next = '0;
        res_ev_next    = 1'b0;
        res_evkey_next = '0;
        valid_next     = valid_reg;
        occ_next       = occ_reg;
        case (func_reg)
            FUNC_LOOKUP:
            begin
                if (found_reg)
                begin
                    mode_next      = MODE_PROMOTE;
                    res_hit_next   = 1'b1;
                    res_price_next = fvalue_reg;
                end
            end
            FUNC_INSERT:
            begin
                if (found_reg)
                begin
                    mode_next    = MODE_PROMOTE;
                    res_hit_next = 1'b1;
                end
                else
                begin
                    mode_next = MODE_INSERT;
                    if (occ_reg >= CNT_LAST && mx_any_reg)
                    begin
                        // Full: the oldest entry gives up its slot.
                        tslot_next     = mx_slot_reg;
                        res_ev_next    = 1'b1;
                        res_evkey_next = mx_key_reg;
                    end
                    else
                    begin
                        tslot_next = free_slot_reg;
                        occ_next   = occ_reg + CNT_W'(1);
                    end
                    valid_next[tslot_next] = 1'b1;
                end
            end
            FUNC_ERASE:
            begin
                if (found_reg)
                begin
                    mode_next             = MODE_ERASE;
                    res_hit_next          = 1'b1;
                    valid_next[fslot_reg] = 1'b0;
                    occ_next              = occ_reg - CNT_W'(1);
                end
            end
            default:
            begin
                mode_next = MODE_NONE;
            end
        endcase
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (pass_end)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = (mode_next == MODE_NONE) ? S_DONE : S_UPD;
            end
            S_UPD:
            begin
                if (pass_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pipe_vld_reg  <= 1'b0;
            valid_reg     <= '0;
            occ_reg       <= '0;
            mode_reg      <= MODE_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Pass counter and read pipeline tag.
            if (pass_active && !pass_end)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else
            begin
                cnt_reg <= '0;
            end
            pipe_vld_reg <= pass_active && (cnt_reg < CNT_LAST);

            if (state_reg == S_DECIDE)
            begin
                mode_reg  <= mode_next;
                valid_reg <= valid_next;
                occ_reg   <= occ_next;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload, scan and result registers.
    always_ff @(posedge clk)
    begin
        pipe_idx_reg <= cnt_reg[IDX_W-1:0];

        if (req_acc)
        begin
            func_reg     <= req.func;
            key_reg      <= req.key;
            price_reg    <= req.price;
            found_reg    <= 1'b0;
            mx_any_reg   <= 1'b0;
            free_any_reg <= 1'b0;
        end

        // Match, oldest entry and first free slot, one entry a cycle.
        if (state_reg == S_SCAN && pipe_vld_reg)
        begin
            if (valid_reg[pipe_idx_reg])
            begin
                if (!found_reg && rd_entry.key == key_reg)
                begin
                    found_reg  <= 1'b1;
                    fslot_reg  <= pipe_idx_reg;
                    fage_reg   <= rd_entry.age;
                    fvalue_reg <= rd_entry.value;
                end
                if (!mx_any_reg || rd_entry.age > mx_age_reg)
                begin
                    mx_any_reg  <= 1'b1;
                    mx_slot_reg <= pipe_idx_reg;
                    mx_age_reg  <= rd_entry.age;
                    mx_key_reg  <= rd_entry.key;
                end
            end
            else if (!free_any_reg)
            begin
                free_any_reg  <= 1'b1;
                free_slot_reg <= pipe_idx_reg;
            end
        end

        if (state_reg == S_DECIDE)
        begin
            tslot_reg     <= tslot_next;
            tage_reg      <= tage_next;
            res_hit_reg   <= res_hit_next;
            res_price_reg <= res_price_next;
            res_ev_reg    <= res_ev_next;
            res_evkey_reg <= res_evkey_next;
        end

        if (out_load)
        begin
            out_hit_reg   <= res_hit_reg;
            out_price_reg <= res_price_reg;
            out_ev_reg    <= res_ev_reg;
            out_evkey_reg <= res_evkey_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = out_hit_reg;
    assign rsp.read_price  = out_price_reg;
    assign rsp.evicted     = out_ev_reg;
    assign rsp.evicted_key = out_evkey_reg;

endmodule

### sv/lpc_checker.sv
module lpc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic                          rsp_hit,
    input logic [lpc_pkg::PRICE_W-1:0]   rsp_read_price,
    input logic                          rsp_evicted,
    input logic [lpc_pkg::KEY_W-1:0]     rsp_evicted_key
);

    logic [1:0] pend_reg;
    logic       req_acc;
    logic       rsp_acc;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    // Requests taken whose responses are not yet delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + {1'b0, req_acc} - {1'b0, rsp_acc};
        end
    end

    // A stalled response holds its word.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
            && $stable(rsp_read_price) && $stable(rsp_evicted) && $stable(rsp_evicted_key))
        else $error("response word changed while stalled");

    // Every response belongs to an earlier request.
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_acc |-> pend_reg != 2'd0)
        else $error("response without a pending request");

    // At most one request in work and one response waiting.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |-> (pend_reg == 2'd0 || pend_reg == 2'd1))
        else $error("request taken with two words outstanding");

    // The block is busy right after it takes a request.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> !req_ready)
        else $error("request port ready right after an accept");

    // A new response appears only from work in progress.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("response raised while the block was idle");

endmodule

bind lru_keyed_price_cache_top lpc_checker u_lpc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_hit         (rsp.hit),
    .rsp_read_price  (rsp.read_price),
    .rsp_evicted     (rsp.evicted),
    .rsp_evicted_key (rsp.evicted_key)
);

### dv/tb_lru_keyed_price_cache_top.sv
import lpc_pkg::*;

// One reply word as the cache should produce it.
typedef struct packed {
    logic               hit;
    logic [PRICE_W-1:0] read_price;
    logic               evicted;
    logic [KEY_W-1:0]   evicted_key;
} cache_reply_t;

// Shadow copy of the LRU cache: predicts the reply to each accepted request
// and checks the reply words in order.
class lru_price_tracker;
    bit                 held[CAPACITY];
    logic [KEY_W-1:0]   slot_key[CAPACITY];
    logic [PRICE_W-1:0] slot_price[CAPACITY];
    int unsigned        slot_age[CAPACITY];
    int unsigned        fill;
    cache_reply_t       expected_replies[$];
    int unsigned        mismatches;

    function new();
        foreach (held[i])
        begin
            held[i] = 1'b0;
            slot_key[i] = '0;
            slot_price[i] = '0;
            slot_age[i] = 0;
        end
        fill = 0;
        mismatches = 0;
    endfunction

    function int pending();
        return expected_replies.size();
    endfunction

    function int find_key(logic [KEY_W-1:0] k);
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (held[i] && slot_key[i] == k)
                return i;
        end
        return -1;
    endfunction

    // Move one entry to rank zero; the entries that were newer age by one.
    function void promote(int s);
        int unsigned rank;
        rank = slot_age[s];
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (held[i] && slot_age[i] < rank)
                slot_age[i]++;
        end
        slot_age[s] = 0;
    endfunction

    function void note_request(logic [FUNC_W-1:0] op, logic [KEY_W-1:0] k,
                               logic [PRICE_W-1:0] p);
        cache_reply_t r;
        int           s;
        int           victim;
        int unsigned  oldest;
        int unsigned  rank;
        r = '0;
        s = find_key(k);
        oldest = 0;
        case (op)
            FUNC_LOOKUP:
            begin
                if (s >= 0)
                begin
                    r.hit = 1'b1;
                    r.read_price = slot_price[s];
                    promote(s);
                end
            end
            FUNC_INSERT:
            begin
                if (s >= 0)
                begin
                    // A present key only gets fresher; its price stays.
                    r.hit = 1'b1;
                    promote(s);
                end
                else
                begin
                    victim = -1;
                    // A full cache gives up its oldest entry.
                    if (fill >= CAPACITY)
                    begin
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            if (held[i] && (victim < 0 || slot_age[i] > oldest))
                            begin
                                oldest = slot_age[i];
                                victim = i;
                            end
                        end
                        if (victim >= 0)
                        begin
                            r.evicted = 1'b1;
                            r.evicted_key = slot_key[victim];
                            held[victim] = 1'b0;
                            fill--;
                        end
                    end
                    // Otherwise the lowest free slot takes the new key.
                    if (victim < 0)
                    begin
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            if (!held[i])
                            begin
                                victim = i;
                                break;
                            end
                        end
                    end
                    if (victim >= 0)
                    begin
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            if (held[i])
                                slot_age[i]++;
                        end
                        held[victim] = 1'b1;
                        slot_key[victim] = k;
                        slot_price[victim] = p;
                        slot_age[victim] = 0;
                        fill++;
                    end
                end
            end
            FUNC_ERASE:
            begin
                if (s >= 0)
                begin
                    // Entries older than the erased one move up a rank.
                    r.hit = 1'b1;
                    rank = slot_age[s];
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (held[i] && slot_age[i] > rank)
                            slot_age[i]--;
                    end
                    held[s] = 1'b0;
                    if (fill > 0)
                        fill--;
                end
            end
            default:
            begin
            end
        endcase
        expected_replies.push_back(r);
    endfunction

    function void check_reply(cache_reply_t got);
        cache_reply_t want;
        if (expected_replies.size() == 0)
        begin
            $error("reply word with no request outstanding");
            mismatches++;
            return;
        end
        want = expected_replies.pop_front();
        if (got.hit !== want.hit)
        begin
            $error("hit: expected %0d, actual %0d", want.hit, got.hit);
            mismatches++;
        end
        if (got.read_price !== want.read_price)
        begin
            $error("read_price: expected %h, actual %h", want.read_price, got.read_price);
            mismatches++;
        end
        if (got.evicted !== want.evicted)
        begin
            $error("evicted: expected %0d, actual %0d", want.evicted, got.evicted);
            mismatches++;
        end
        if (got.evicted_key !== want.evicted_key)
        begin
            $error("evicted_key: expected %h, actual %h", want.evicted_key, got.evicted_key);
            mismatches++;
        end
    endfunction
endclass

module tb_lru_keyed_price_cache_top;

    // The one operation code with no action.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
    localparam int POOL_SIZE    = 24;
    localparam int CHUNKS       = 9;
    localparam int CHUNK_WORDS  = 50;

    logic clk = 1'b0;
    logic rst_n;
    int   idle_pct;
    int   quiet_cycles;

    lru_price_tracker tracker = new();

    lpc_req_if req ();
    lpc_rsp_if rsp ();

    lru_keyed_price_cache_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one request word, possibly after an idle burst, and wait for it to be taken.
    task automatic send_request(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] k,
                                input logic [PRICE_W-1:0] p);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.func  <= op;
        req.key   <= k;
        req.price <= p;
        do
        begin
            @(posedge clk);
        end
        while (!req.ready);
    endtask

    // Hold off new requests until every outstanding reply is back.
    task automatic wait_drained();
        req.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (tracker.pending() != 0);
    endtask

    // Receiver side: ready drops for random bursts while idling is enabled.
    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 3)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            rsp.ready <= 1'b1;
        end
    end

    // Check reply words, record accepted requests, and watch for a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
                tracker.check_reply({rsp.hit, rsp.read_price, rsp.evicted, rsp.evicted_key});
            if (req.valid && req.ready)
                tracker.note_request(req.func, req.key, req.price);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence: reset, directed words, then random traffic in chunks.
    initial
    begin
        logic [KEY_W-1:0]   key_pool[POOL_SIZE];
        logic [FUNC_W-1:0]  op;
        logic [KEY_W-1:0]   k;
        logic [PRICE_W-1:0] p;
        int                 span;
        int                 pick;
        int                 roll;

        rst_n        = 1'b0;
        quiet_cycles = 0;
        idle_pct     = 0;
        req.valid   <= 1'b0;
        req.func    <= FUNC_LOOKUP;
        req.key     <= '0;
        req.price   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Empty cache: the unused code, then misses on lookup and erase.
        send_request(FUNC_UNUSED, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(FUNC_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(FUNC_ERASE,  32'h8000_0000, 32'h0000_0000);

        // Extreme keys and prices.
        send_request(FUNC_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(FUNC_INSERT, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(FUNC_INSERT, 32'h0000_0000, 32'h0001_0000);
        send_request(FUNC_INSERT, 32'hFFFF_FFFF, 32'h8000_0001);
        send_request(FUNC_LOOKUP, 32'h8000_0000, 32'h0000_0000);
        send_request(FUNC_LOOKUP, 32'h7FFF_FFFF, 32'hFFFF_FFFF);

        // Insert of a present key keeps the old price.
        send_request(FUNC_INSERT, 32'h0000_0000, 32'hDEAD_BEEF);
        send_request(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000);

        // Erase a middle-aged entry, then miss on it twice.
        send_request(FUNC_ERASE,  32'h7FFF_FFFF, 32'h0000_0000);
        send_request(FUNC_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(FUNC_ERASE,  32'h7FFF_FFFF, 32'h0000_0000);

        // Unused code on a present key changes nothing.
        send_request(FUNC_UNUSED, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(FUNC_LOOKUP, 32'h8000_0000, 32'h0000_0000);

        wait_drained();

        foreach (key_pool[i])
            key_pool[i] = $urandom();
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;

        // Random traffic over a key pool whose span sets how often the cache fills.
        for (int c = 0; c < CHUNKS; c++)
        begin
            if (c == 3 || c == 6)
                wait_drained();
            if (c >= CHUNKS - 2)
                idle_pct = 0;
            else
            begin
                roll = $urandom_range(0, 2);
                idle_pct = (roll == 0) ? 0 : ((roll == 1) ? 15 : 40);
            end
            span = $urandom_range(6, POOL_SIZE);
            key_pool[$urandom_range(2, POOL_SIZE - 1)] = $urandom();
            for (int n = 0; n < CHUNK_WORDS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 35)
                    op = FUNC_LOOKUP;
                else if (roll < 75)
                    op = FUNC_INSERT;
                else if (roll < 93)
                    op = FUNC_ERASE;
                else
                    op = FUNC_UNUSED;
                pick = $urandom_range(0, span - 1);
                k = ($urandom_range(0, 99) < 88) ? key_pool[pick] : $urandom();
                roll = $urandom_range(0, 9);
                if (roll == 0)
                    p = '0;
                else if (roll == 1)
                    p = '1;
                else
                    p = $urandom();
                send_request(op, k, p);
            end
        end
        req.valid <= 1'b0;

        // Let every reply arrive, then give the block time to show a stray word.
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
sv/lpc_pkg.sv
sv/lpc_if.sv
sv/lpc_ram.sv
sv/lru_keyed_price_cache_top.sv
sv/lpc_checker.sv
dv/tb_lru_keyed_price_cache_top.sv
